@@ hdl/mesh_tangent_accumulator_macros.svh @@
// assertion macros for the tangent accumulator
// no dependencies; taken in by the top level
`ifndef MESH_TANGENT_ACCUMULATOR_MACROS_SVH
`define MESH_TANGENT_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define MTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tangent accumulator check failed");

// next-cycle implication
`define MTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tangent accumulator check failed");

`endif

@@ hdl/mta_pkg.sv @@
// shared types, codes and constants of the tangent accumulator
// no dependencies
package mta_pkg;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_TRIANGLE = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DET = 2'd1;
    localparam logic [1:0] STATUS_BAD      = 2'd2;

    localparam logic [47:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] VAL_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [23:0] tu;
        logic signed [23:0] tv;
    } vertex_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] ia;
        logic [11:0] ib;
        logic [11:0] ic;
        vertex_t     vtx;
    } item_t;

    // element 0..5: tangent x,y,z then bitangent x,y,z
    typedef logic [5:0][47:0] row_t;

    typedef struct packed {
        row_t       vals;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic               start;
        logic signed [58:0] num;
        logic signed [50:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quot;
    } div_rsp_t;

endpackage

@@ hdl/mta_front.sv @@
// front end: classifies incoming commands and queues them for the back end
// depends on mta_pkg
module mta_front #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic [11:0]         first_index,
    input  logic [11:0]         second_index,
    input  logic [11:0]         third_index,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [23:0]  tex_u,
    input  logic signed [23:0]  tex_v,
    output logic                q_valid,
    input  logic                q_pop,
    output mta_pkg::item_t      q_head
);

    localparam logic [16:0] DEPTH_L = 17'(VERTEX_DEPTH);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    mta_pkg::item_t     fifo_mem [QDEPTH];
    mta_pkg::item_t     item_in;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               a_ok, b_ok, c_ok;
    logic               do_push, do_pop;

    assign a_ok = {5'b0, first_index} < DEPTH_L;
    assign b_ok = {5'b0, second_index} < DEPTH_L;
    assign c_ok = {5'b0, third_index} < DEPTH_L;

    always_comb
    begin
        item_in.ia     = first_index;
        item_in.ib     = second_index;
        item_in.ic     = third_index;
        item_in.vtx.px = pos_x;
        item_in.vtx.py = pos_y;
        item_in.vtx.pz = pos_z;
        item_in.vtx.tu = tex_u;
        item_in.vtx.tv = tex_v;
        case (command)
            mta_pkg::CMD_WRITE:    item_in.kind = a_ok ? mta_pkg::KIND_WRITE : mta_pkg::KIND_BAD;
            mta_pkg::CMD_TRIANGLE: item_in.kind = (a_ok && b_ok && c_ok) ?
                                                  mta_pkg::KIND_TRI : mta_pkg::KIND_BAD;
            mta_pkg::CMD_READ:     item_in.kind = a_ok ? mta_pkg::KIND_READ : mta_pkg::KIND_BAD;
            default:               item_in.kind = mta_pkg::KIND_BAD;
        endcase
    end

    assign full    = count_reg == (QPTR_W+1)'(QDEPTH);
    assign q_valid = count_reg != '0;
    assign q_head  = fifo_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            fifo_mem[wr_ptr_reg] <= item_in;
    end

endmodule

@@ hdl/mta_div.sv @@
// signed fixed-point divider: trunc(num * 2^16 / den), saturated to 48 bits
// one quotient bit per cycle; depends on mta_pkg
module mta_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mta_pkg::div_req_t  req,
    output mta_pkg::div_rsp_t  rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam int QBITS = 47;

    logic [1:0]       state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [57:0]      n_reg, n_next;
    logic [49:0]      d_reg, d_next;
    logic [49:0]      r_reg, r_next;
    logic [46:0]      sh_reg, sh_next;
    logic [46:0]      q_reg, q_next;
    logic             done_reg, done_next;
    logic [47:0]      quot_reg, quot_next;
    logic [50:0]      shifted;
    logic [50:0]      trial_diff;
    logic             trial_ge;

    assign shifted    = {r_reg, sh_reg[46]};
    assign trial_ge   = shifted >= {1'b0, d_reg};
    assign trial_diff = shifted - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = req.num[58] ^ req.den[50];
                    n_next     = req.num[58] ? 58'(-req.num) : 58'(req.num);
                    d_next     = req.den[50] ? 50'(-req.den) : 50'(req.den);
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                // integer part of the quotient must stay below 2^31
                if ({23'b0, n_reg[57:31]} >= d_reg)
                begin
                    done_next  = 1'b1;
                    quot_next  = neg_reg ? mta_pkg::VAL_MIN : mta_pkg::VAL_MAX;
                    state_next = D_IDLE;
                end
                else
                begin
                    r_next     = {23'b0, n_reg[57:31]};
                    sh_next    = {n_reg[30:0], 16'b0};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                r_next   = trial_ge ? trial_diff[49:0] : shifted[49:0];
                q_next   = {q_reg[45:0], trial_ge};
                sh_next  = {sh_reg[45:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(QBITS - 1))
                begin
                    done_next  = 1'b1;
                    quot_next  = neg_reg ? -{1'b0, q_next} : {1'b0, q_next};
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ hdl/mta_back.sv @@
// back end: vertex and sum stores, delta/product sequencing, accumulation
// depends on mta_pkg; drives the shared divider
module mta_back #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mta_pkg::item_t      q_head,
    output logic                q_pop,
    output mta_pkg::div_req_t   div_req,
    input  mta_pkg::div_rsp_t   div_rsp,
    output logic                out_valid,
    output mta_pkg::result_t    out_res,
    input  logic                out_pop
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int MUL_STEPS = 14;
    localparam int NCOMP = 6;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_VA     = 4'd2;
    localparam logic [3:0] S_VB     = 4'd3;
    localparam logic [3:0] S_VC     = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DIVW   = 4'd7;
    localparam logic [3:0] S_ACCRD  = 4'd8;
    localparam logic [3:0] S_ACCWR  = 4'd9;
    localparam logic [3:0] S_RDSUM  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    mta_pkg::vertex_t   vmem [VERTEX_DEPTH];
    mta_pkg::row_t      smem [VERTEX_DEPTH];

    logic [3:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [2:0]         comp_reg, comp_next;
    logic [1:0]         corner_reg, corner_next;
    logic               out_valid_reg, out_valid_next;

    mta_pkg::item_t     cur_reg;
    mta_pkg::vertex_t   v0_reg, v1_reg, vrd_data_reg;
    mta_pkg::row_t      srd_data_reg, res_reg, swr_data;
    mta_pkg::result_t   out_reg;
    logic [1:0]         status_reg;

    logic signed [32:0] dp1_reg [3];
    logic signed [32:0] dp2_reg [3];
    logic signed [24:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] prod_reg, first_reg;
    logic signed [58:0] pair_diff;
    logic signed [50:0] det_reg;
    logic signed [58:0] num_reg [NCOMP];
    logic [3:0]         k_step;
    logic [2:0]         pair;

    logic               vrd_en, vwr_en, srd_en, swr_en;
    logic [AW-1:0]      vrd_addr, srd_addr, swr_addr;
    logic [AW-1:0]      a_addr, b_addr, c_addr, acc_addr;
    logic               emit_go;
    integer             i;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic signed [48:0] s;
        s = $signed({a[47], a}) + $signed({b[47], b});
        if (s[48] != s[47])
            sat_add = s[48] ? mta_pkg::VAL_MIN : mta_pkg::VAL_MAX;
        else
            sat_add = s[47:0];
    endfunction

    assign a_addr = AW'(cur_reg.ia);
    assign b_addr = AW'(cur_reg.ib);
    assign c_addr = AW'(cur_reg.ic);

    always_comb
    begin
        case (corner_reg)
            2'd0:    acc_addr = a_addr;
            2'd1:    acc_addr = b_addr;
            default: acc_addr = c_addr;
        endcase
    end

    always_comb
    begin
        for (i = 0; i < NCOMP; i = i + 1)
            swr_data[i] = sat_add(srd_data_reg[i], res_reg[i]);
        if (state_reg == S_DECODE)
            swr_data = '0;
    end

    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || out_pop);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        vrd_en         = 1'b0;
        vrd_addr       = a_addr;
        vwr_en         = 1'b0;
        srd_en         = 1'b0;
        srd_addr       = a_addr;
        swr_en         = 1'b0;
        swr_addr       = a_addr;
        if (out_pop)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (cur_reg.kind)
                    mta_pkg::KIND_WRITE:
                    begin
                        vwr_en     = 1'b1;
                        swr_en     = 1'b1;
                        state_next = S_EMIT;
                    end
                    mta_pkg::KIND_READ:
                    begin
                        srd_en     = 1'b1;
                        state_next = S_RDSUM;
                    end
                    mta_pkg::KIND_TRI:
                    begin
                        vrd_en     = 1'b1;
                        state_next = S_VA;
                    end
                    default: state_next = S_EMIT;
                endcase
            end
            S_VA:
            begin
                vrd_en     = 1'b1;
                vrd_addr   = b_addr;
                state_next = S_VB;
            end
            S_VB:
            begin
                vrd_en     = 1'b1;
                vrd_addr   = c_addr;
                state_next = S_VC;
            end
            S_VC:
            begin
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(MUL_STEPS))
                begin
                    comp_next  = '0;
                    state_next = (det_reg == '0) ? S_EMIT : S_DIV;
                end
            end
            S_DIV: state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    if (comp_reg == 3'(NCOMP - 1))
                    begin
                        corner_next = '0;
                        state_next  = S_ACCRD;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_ACCRD:
            begin
                srd_en     = 1'b1;
                srd_addr   = acc_addr;
                state_next = S_ACCWR;
            end
            S_ACCWR:
            begin
                swr_en      = 1'b1;
                swr_addr    = acc_addr;
                corner_next = corner_reg + 1'b1;
                state_next  = (corner_reg == 2'd2) ? S_EMIT : S_ACCRD;
            end
            S_RDSUM: state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        case (step_reg)
            4'd0:    begin mul_a = 33'(du1_reg);  mul_b = dv2_reg; end
            4'd1:    begin mul_a = 33'(dv1_reg);  mul_b = du2_reg; end
            4'd2:    begin mul_a = dp1_reg[0];    mul_b = dv2_reg; end
            4'd3:    begin mul_a = dp2_reg[0];    mul_b = dv1_reg; end
            4'd4:    begin mul_a = dp1_reg[1];    mul_b = dv2_reg; end
            4'd5:    begin mul_a = dp2_reg[1];    mul_b = dv1_reg; end
            4'd6:    begin mul_a = dp1_reg[2];    mul_b = dv2_reg; end
            4'd7:    begin mul_a = dp2_reg[2];    mul_b = dv1_reg; end
            4'd8:    begin mul_a = dp2_reg[0];    mul_b = du1_reg; end
            4'd9:    begin mul_a = dp1_reg[0];    mul_b = du2_reg; end
            4'd10:   begin mul_a = dp2_reg[1];    mul_b = du1_reg; end
            4'd11:   begin mul_a = dp1_reg[1];    mul_b = du2_reg; end
            4'd12:   begin mul_a = dp2_reg[2];    mul_b = du1_reg; end
            4'd13:   begin mul_a = dp1_reg[2];    mul_b = du2_reg; end
            default: begin mul_a = '0;            mul_b = '0;      end
        endcase
    end

    assign k_step    = step_reg - 1'b1;
    assign pair      = k_step[3:1];
    assign pair_diff = 59'(first_reg) - 59'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
            cur_reg <= q_head;
        if (state_reg == S_DECODE)
        begin
            res_reg    <= '0;
            status_reg <= (cur_reg.kind == mta_pkg::KIND_BAD) ?
                          mta_pkg::STATUS_BAD : mta_pkg::STATUS_OK;
        end
        if (state_reg == S_VA)
            v0_reg <= vrd_data_reg;
        if (state_reg == S_VB)
            v1_reg <= vrd_data_reg;
        if (state_reg == S_VC)
        begin
            dp1_reg[0] <= 33'($signed(v1_reg.px)) - 33'($signed(v0_reg.px));
            dp1_reg[1] <= 33'($signed(v1_reg.py)) - 33'($signed(v0_reg.py));
            dp1_reg[2] <= 33'($signed(v1_reg.pz)) - 33'($signed(v0_reg.pz));
            dp2_reg[0] <= 33'($signed(vrd_data_reg.px)) - 33'($signed(v0_reg.px));
            dp2_reg[1] <= 33'($signed(vrd_data_reg.py)) - 33'($signed(v0_reg.py));
            dp2_reg[2] <= 33'($signed(vrd_data_reg.pz)) - 33'($signed(v0_reg.pz));
            du1_reg    <= 25'($signed(v1_reg.tu)) - 25'($signed(v0_reg.tu));
            dv1_reg    <= 25'($signed(v1_reg.tv)) - 25'($signed(v0_reg.tv));
            du2_reg    <= 25'($signed(vrd_data_reg.tu)) - 25'($signed(v0_reg.tu));
            dv2_reg    <= 25'($signed(vrd_data_reg.tv)) - 25'($signed(v0_reg.tv));
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= mul_a * mul_b;
            // fold the product in prod_reg, issued at step k_step, into its pair
            if (step_reg != '0)
            begin
                if (!k_step[0])
                    first_reg <= prod_reg;
                else if (pair == '0)
                    det_reg <= 51'(pair_diff);
                else
                    num_reg[pair - 1'b1] <= pair_diff;
            end
            if (step_reg == 4'(MUL_STEPS) && det_reg == '0)
                status_reg <= mta_pkg::STATUS_ZERO_DET;
        end
        if (state_reg == S_DIVW && div_rsp.done)
            res_reg[comp_reg] <= div_rsp.quot;
        if (state_reg == S_RDSUM)
            res_reg <= srd_data_reg;
        if (emit_go)
        begin
            out_reg.vals   <= res_reg;
            out_reg.status <= status_reg;
        end
        step_reg   <= step_next;
        comp_reg   <= comp_next;
        corner_reg <= corner_next;
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (vwr_en)
            vmem[a_addr] <= cur_reg.vtx;
        if (vrd_en)
            vrd_data_reg <= vmem[vrd_addr];
    end

    // tangent and bitangent sum store, one row of six sums per vertex
    always_ff @(posedge clk)
    begin
        if (swr_en)
            smem[swr_addr] <= swr_data;
        if (srd_en)
            srd_data_reg <= smem[srd_addr];
    end

    assign div_req.start = state_reg == S_DIV;
    assign div_req.num   = num_reg[comp_reg];
    assign div_req.den   = det_reg;
    assign out_valid     = out_valid_reg;
    assign out_res       = out_reg;

endmodule

@@ hdl/mesh_tangent_accumulator.sv @@
// from input transfer to result, a triangle takes 3 vertex reads, 15 multiplier steps,
// six quotients from the shared one-bit-per-cycle divider and a sum read and write for
// each corner; a degenerate triangle skips the divider and the sum update
// the back end handles one command at a time and waits to emit while a result is untaken
// on reset the queue, sequencer and result valid flag are cleared; vertex and sum stores hold
// no reset value and are valid once their vertex is written
`include "mesh_tangent_accumulator_macros.svh"

module mesh_tangent_accumulator #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic [11:0]         first_index,
    input  logic [11:0]         second_index,
    input  logic [11:0]         third_index,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [23:0]  tex_u,
    input  logic signed [23:0]  tex_v,
    output logic                empty,
    input  logic                pop,
    output logic signed [47:0]  tan_x,
    output logic signed [47:0]  tan_y,
    output logic signed [47:0]  tan_z,
    output logic signed [47:0]  bitan_x,
    output logic signed [47:0]  bitan_y,
    output logic signed [47:0]  bitan_z,
    output logic [1:0]          status
);

    logic               q_valid;
    logic               q_pop;
    mta_pkg::item_t     q_head;
    mta_pkg::div_req_t  div_req;
    mta_pkg::div_rsp_t  div_rsp;
    logic               out_valid;
    mta_pkg::result_t   out_res;

    mta_front #(
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .first_index  (first_index),
        .second_index (second_index),
        .third_index  (third_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_head       (q_head)
    );

    mta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mta_back #(
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_pop   (pop)
    );

    assign empty   = !out_valid;
    assign tan_x   = out_res.vals[0];
    assign tan_y   = out_res.vals[1];
    assign tan_z   = out_res.vals[2];
    assign bitan_x = out_res.vals[3];
    assign bitan_y = out_res.vals[4];
    assign bitan_z = out_res.vals[5];
    assign status  = out_res.status;

    `MTA_ASSERT_NOW(a_pop_needs_item, clk, rst_n, q_pop, q_valid)
    `MTA_ASSERT_NOW(a_div_start_not_busy, clk, rst_n, div_req.start, !div_rsp.done)
    `MTA_ASSERT_NEXT(a_transfer_queued, clk, rst_n, push && !full, q_valid)

endmodule

@@ dv/mesh_tangent_accumulator_tb.sv @@
// self-checking mesh tangent accumulator testbench: vertex writes, triangles, sum reads, bad commands
// depends on mta_pkg and the mesh_tangent_accumulator rtl; predicts every result internally
`timescale 1ns / 100ps

module mesh_tangent_accumulator_tb;

    localparam int NVERT = 4096;
    localparam int HOLD_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [11:0] first_index;
    logic [11:0] second_index;
    logic [11:0] third_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic        empty;
    logic        pop;
    logic signed [47:0] tan_x;
    logic signed [47:0] tan_y;
    logic signed [47:0] tan_z;
    logic signed [47:0] bitan_x;
    logic signed [47:0] bitan_y;
    logic signed [47:0] bitan_z;
    logic [1:0]  status;

    mesh_tangent_accumulator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .first_index  (first_index),
        .second_index (second_index),
        .third_index  (third_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .empty        (empty),
        .pop          (pop),
        .tan_x        (tan_x),
        .tan_y        (tan_y),
        .tan_z        (tan_z),
        .bitan_x      (bitan_x),
        .bitan_y      (bitan_y),
        .bitan_z      (bitan_z),
        .status       (status)
    );

    // shadow copy of the vertex and sum stores
    logic signed [31:0] shadow_px [NVERT];
    logic signed [31:0] shadow_py [NVERT];
    logic signed [31:0] shadow_pz [NVERT];
    logic signed [23:0] shadow_tu [NVERT];
    logic signed [23:0] shadow_tv [NVERT];
    logic signed [47:0] tangent_sum [NVERT][3];
    logic signed [47:0] bitangent_sum [NVERT][3];
    bit                 loaded [NVERT];
    int                 loaded_list [$];

    mta_pkg::result_t expected_results [$];

    int errors = 0;
    int n_sent;
    int n_checked = 0;
    int n_triangles;
    int n_zero_det;
    int n_full_stalls;
    int burst_left;
    bit gaps_on;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int pop_mode = 0;
    int pop_phase = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #20000000;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    // trunc(num * 2^16 / den) saturated to 48 bits
    function automatic logic signed [47:0] fixed_quotient(longint num, longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n << 16) / d;
        if (q >= (128'd1 << 47))
            return neg ? mta_pkg::VAL_MIN : mta_pkg::VAL_MAX;
        return neg ? -q[47:0] : q[47:0];
    endfunction

    function automatic logic signed [47:0] sat_add(logic signed [47:0] a, logic signed [47:0] b);
        logic signed [48:0] s;
        s = a + b;
        if (s > $signed({1'b0, mta_pkg::VAL_MAX}))
            return mta_pkg::VAL_MAX;
        if (s < $signed({1'b1, mta_pkg::VAL_MIN}))
            return mta_pkg::VAL_MIN;
        return s[47:0];
    endfunction

    function automatic mta_pkg::result_t predict_tangents(logic [1:0] cmd, int ia, int ib, int ic,
                                                          mta_pkg::vertex_t v);
        mta_pkg::result_t r;
        longint  dp1 [3];
        longint  dp2 [3];
        longint  du1, dv1, du2, dv2, det;
        int      corner [3];
        r = '0;
        r.status = mta_pkg::STATUS_OK;
        case (cmd)
            mta_pkg::CMD_WRITE:
            begin
                shadow_px[ia] = v.px;
                shadow_py[ia] = v.py;
                shadow_pz[ia] = v.pz;
                shadow_tu[ia] = v.tu;
                shadow_tv[ia] = v.tv;
                for (int c = 0; c < 3; c++)
                begin
                    tangent_sum[ia][c] = '0;
                    bitangent_sum[ia][c] = '0;
                end
                if (!loaded[ia])
                begin
                    loaded[ia] = 1'b1;
                    loaded_list.insert(loaded_list.size(), ia);
                end
            end
            mta_pkg::CMD_TRIANGLE:
            begin
                dp1[0] = longint'(shadow_px[ib]) - longint'(shadow_px[ia]);
                dp1[1] = longint'(shadow_py[ib]) - longint'(shadow_py[ia]);
                dp1[2] = longint'(shadow_pz[ib]) - longint'(shadow_pz[ia]);
                dp2[0] = longint'(shadow_px[ic]) - longint'(shadow_px[ia]);
                dp2[1] = longint'(shadow_py[ic]) - longint'(shadow_py[ia]);
                dp2[2] = longint'(shadow_pz[ic]) - longint'(shadow_pz[ia]);
                du1 = longint'(shadow_tu[ib]) - longint'(shadow_tu[ia]);
                dv1 = longint'(shadow_tv[ib]) - longint'(shadow_tv[ia]);
                du2 = longint'(shadow_tu[ic]) - longint'(shadow_tu[ia]);
                dv2 = longint'(shadow_tv[ic]) - longint'(shadow_tv[ia]);
                det = du1 * dv2 - dv1 * du2;
                n_triangles++;
                if (det == 0)
                begin
                    r.status = mta_pkg::STATUS_ZERO_DET;
                    n_zero_det++;
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        r.vals[c] = fixed_quotient(dp1[c] * dv2 - dp2[c] * dv1, det);
                        r.vals[3 + c] = fixed_quotient(dp2[c] * du1 - dp1[c] * du2, det);
                    end
                    corner[0] = ia;
                    corner[1] = ib;
                    corner[2] = ic;
                    for (int k = 0; k < 3; k++)
                        for (int c = 0; c < 3; c++)
                        begin
                            tangent_sum[corner[k]][c] =
                                sat_add(tangent_sum[corner[k]][c], r.vals[c]);
                            bitangent_sum[corner[k]][c] =
                                sat_add(bitangent_sum[corner[k]][c], r.vals[3 + c]);
                        end
                end
            end
            mta_pkg::CMD_READ:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r.vals[c] = tangent_sum[ia][c];
                    r.vals[3 + c] = bitangent_sum[ia][c];
                end
            end
            default:
                r.status = mta_pkg::STATUS_BAD;
        endcase
        return r;
    endfunction

    // one transfer into the block; called and returns just after a falling edge, once it is taken
    task automatic send_command(logic [1:0] cmd, int ia, int ib, int ic, mta_pkg::vertex_t v);
        if (gaps_on && burst_left == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        command      = cmd;
        first_index  = ia[11:0];
        second_index = ib[11:0];
        third_index  = ic[11:0];
        pos_x        = v.px;
        pos_y        = v.py;
        pos_z        = v.pz;
        tex_u        = v.tu;
        tex_v        = v.tv;
        push         = 1'b1;
        @(posedge clk);
        while (full)
        begin
            n_full_stalls++;
            @(posedge clk);
        end
        expected_results.insert(expected_results.size(), predict_tangents(cmd, ia, ib, ic, v));
        n_sent++;
        @(negedge clk);
    endtask

    function automatic mta_pkg::vertex_t random_vertex(bit wide);
        mta_pkg::vertex_t v;
        if (wide)
        begin
            v.px = $urandom;
            v.py = $urandom;
            v.pz = $urandom;
            v.tu = 24'($urandom);
            v.tv = 24'($urandom);
        end
        else
        begin
            v.px = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            v.py = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            v.pz = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            v.tu = 24'($urandom_range(0, 32'h0003_FFFF)) - 24'sh02_0000;
            v.tv = 24'($urandom_range(0, 32'h0003_FFFF)) - 24'sh02_0000;
        end
        return v;
    endfunction

    function automatic mta_pkg::vertex_t make_vertex(int px, int py, int pz, int tu, int tv);
        mta_pkg::vertex_t v;
        v.px = px;
        v.py = py;
        v.pz = pz;
        v.tu = tu[23:0];
        v.tv = tv[23:0];
        return v;
    endfunction

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    task automatic send_idle();
        push = 1'b0;
    endtask

    task automatic test_extremes();
        mta_pkg::vertex_t z;
        z = '0;
        // extreme indices and extreme field values
        send_command(mta_pkg::CMD_WRITE, 0, 0, 0,
                     make_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 0, -(1 << 23), (1 << 23) - 1));
        send_command(mta_pkg::CMD_WRITE, NVERT - 1, 0, 0,
                     make_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, -1, (1 << 23) - 1, -(1 << 23)));
        send_command(mta_pkg::CMD_WRITE, 2730, 0, 0, make_vertex(0, 0, 32'sh7FFF_FFFF, 0, 0));
        send_command(mta_pkg::CMD_TRIANGLE, 0, NVERT - 1, 2730, z);
        send_command(mta_pkg::CMD_TRIANGLE, NVERT - 1, 2730, 0, z);
        send_command(mta_pkg::CMD_READ, 0, 0, 0, z);
        send_command(mta_pkg::CMD_READ, NVERT - 1, 0, 0, z);
        send_command(mta_pkg::CMD_READ, 2730, 0, 0, z);
    endtask

    task automatic test_saturation();
        mta_pkg::vertex_t z;
        z = '0;
        // unit determinant with full-range positions drives quotients and sums to the rails
        send_command(mta_pkg::CMD_WRITE, 10, 0, 0, make_vertex(0, 0, 0, 0, 0));
        send_command(mta_pkg::CMD_WRITE, 11, 0, 0,
                     make_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0));
        send_command(mta_pkg::CMD_WRITE, 12, 0, 0,
                     make_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1));
        repeat (3)
            send_command(mta_pkg::CMD_TRIANGLE, 10, 11, 12, z);
        send_command(mta_pkg::CMD_READ, 10, 0, 0, z);
        send_command(mta_pkg::CMD_READ, 12, 0, 0, z);
        // rewrite clears the sums
        send_command(mta_pkg::CMD_WRITE, 12, 0, 0, make_vertex(5, 6, 7, 0, 1));
        send_command(mta_pkg::CMD_READ, 12, 0, 0, z);
    endtask

    task automatic test_degenerate();
        mta_pkg::vertex_t z;
        z = '0;
        send_command(mta_pkg::CMD_WRITE, 20, 0, 0, make_vertex(0, 0, 0, 100, 200));
        send_command(mta_pkg::CMD_WRITE, 21, 0, 0, make_vertex(65536, 0, 0, 200, 400));
        send_command(mta_pkg::CMD_WRITE, 22, 0, 0, make_vertex(0, 65536, 0, 300, 600));
        // collinear uvs, then a repeated corner
        send_command(mta_pkg::CMD_TRIANGLE, 20, 21, 22, z);
        send_command(mta_pkg::CMD_TRIANGLE, 20, 20, 21, z);
        send_command(mta_pkg::CMD_READ, 20, 0, 0, z);
    endtask

    task automatic test_bad_command();
        send_command(mta_pkg::KIND_BAD, 7, 4095, 0, random_vertex(1'b1));
        send_command(mta_pkg::KIND_BAD, 0, 0, 4095, random_vertex(1'b1));
    endtask

    // receiver holds off while writes and sum reads keep arriving, so the block fills and pushes back
    task automatic test_backpressure();
        mta_pkg::vertex_t z;
        z = '0;
        gaps_on = 1'b0;
        hold_req++;
        for (int i = 0; i < 80; i++)
            if (i % 3 == 2)
                send_command(mta_pkg::CMD_READ, any_loaded(), 0, 0, z);
            else
                send_command(mta_pkg::CMD_WRITE, $urandom_range(0, NVERT - 1), 0, 0,
                             random_vertex(i[0]));
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_idle();
        while (expected_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // small meshes: a few vertices, triangles over them, then reads of their sums
    task automatic test_random_meshes(int target);
        int      base;
        int      nv;
        int      idx [8];
        mta_pkg::vertex_t z;
        z = '0;
        while (n_sent < target)
        begin
            nv = $urandom_range(3, 6);
            base = $urandom_range(0, NVERT - 1);
            for (int i = 0; i < nv; i++)
            begin
                idx[i] = ($urandom_range(0, 3) == 0) ? any_loaded()
                                                      : (base + 37 * i) % NVERT;
                send_command(mta_pkg::CMD_WRITE, idx[i], 0, 0,
                             random_vertex($urandom_range(0, 4) == 0));
            end
            repeat ($urandom_range(1, 3))
                send_command(mta_pkg::CMD_TRIANGLE, idx[$urandom_range(0, nv - 1)],
                             idx[$urandom_range(0, nv - 1)], idx[$urandom_range(0, nv - 1)], z);
            repeat ($urandom_range(1, 3))
                send_command(mta_pkg::CMD_READ, idx[$urandom_range(0, nv - 1)], 0, 0, z);
            // at times some noise: a bad command, or a loose triangle or read on older vertices
            case ($urandom_range(0, 5))
                0: send_command(mta_pkg::KIND_BAD, $urandom_range(0, NVERT - 1),
                                $urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1),
                                random_vertex(1'b1));
                1: send_command(mta_pkg::CMD_TRIANGLE, any_loaded(), any_loaded(),
                                any_loaded(), z);
                2: send_command(mta_pkg::CMD_READ, any_loaded(), 0, 0, z);
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0)
                gaps_on = ~gaps_on;
        end
    endtask

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (hold_left > 0)
        begin
            pop = 1'b0;
            hold_left--;
        end
        else if (hold_req != hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done++;
            pop = 1'b0;
        end
        else
        begin
            if (pop_phase == 0)
            begin
                pop_phase = $urandom_range(50, 400);
                pop_mode = $urandom_range(0, 2);
            end
            pop_phase--;
            case (pop_mode)
                0: pop = 1'b1;
                1: pop = ($urandom_range(0, 3) != 0);
                default: pop = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        mta_pkg::result_t want;
        logic [47:0] got [6];
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, status %0d", $time, status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                got[0] = tan_x;
                got[1] = tan_y;
                got[2] = tan_z;
                got[3] = bitan_x;
                got[4] = bitan_y;
                got[5] = bitan_z;
                for (int j = 0; j < 6; j++)
                    if (got[j] !== want.vals[j])
                    begin
                        $display("%0t: value %0d expected %h actual %h",
                                 $time, j, want.vals[j], got[j]);
                        errors++;
                    end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    initial
    begin
        int waited;
        n_sent = 0;
        n_triangles = 0;
        n_zero_det = 0;
        n_full_stalls = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        push = 1'b0;
        command = mta_pkg::CMD_WRITE;
        first_index = '0;
        second_index = '0;
        third_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        tex_u = '0;
        tex_v = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_saturation();
        test_degenerate();
        test_bad_command();
        test_drain_pause();
        test_backpressure();
        test_drain_pause();
        test_random_meshes(1750);

        send_idle();
        waited = 0;
        while (expected_results.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (400) @(negedge clk);
        $display("sent %0d commands, %0d results checked, %0d triangles (%0d degenerate)",
                 n_sent, n_checked, n_triangles, n_zero_det);
        $display("input held back for %0d cycles by a full queue", n_full_stalls);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
